### src/fxa_pkg.sv
// fxa_pkg: shared types and constants for the q24.8 fixed point alu
// operation codes, pipeline control struct and default fraction width
// no dependencies
`default_nettype none
package fxa_pkg;
	localparam int FRAC_W_DEF = 8;
	localparam int DW = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_EQ = 4'd4, OP_NE = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
		OP_LT = 4'd8, OP_GT = 4'd9, OP_MAX = 4'd10, OP_MIN = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef struct packed {
		op_t             op;
		logic            neg;
		logic [DW-1:0]   dmag;
		logic [DW-1:0]   res;
		logic            cmp;
		logic            dbz;
	} ctl_t;
endpackage
`default_nettype wire

### src/fxa_req_if.sv
// fxa_req_if: request channel, valid/ready with op code and two operands
// depends on nothing
`default_nettype none
interface fxa_req_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  req_type;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	modport source (output valid, req_type, operand_a, operand_b, input ready);
	modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

### src/fxa_rsp_if.sv
// fxa_rsp_if: result channel, valid/ready with value and three flags
// depends on nothing
`default_nettype none
interface fxa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic               divide_by_zero;
	logic               saturated;
	modport source (output valid, result_value, compare_true, divide_by_zero, saturated,
		input ready);
	modport sink (input valid, result_value, compare_true, divide_by_zero, saturated,
		output ready);
endinterface
`default_nettype wire

### src/fxa_div_step.sv
// fxa_div_step: one restoring division step, one quotient bit
// shifts the dividend msb into the remainder and the quotient bit into the lsb
`default_nettype none
module fxa_div_step #(
	parameter int NW = 40
) (
	input  wire logic [NW-1:0] nq_in,
	input  wire logic [31:0]   rem_in,
	input  wire logic [31:0]   dmag,
	output logic      [NW-1:0] nq_out,
	output logic      [31:0]   rem_out
);
	logic [32:0] trial;
	logic        ge;

	always_comb begin
		trial = {rem_in, nq_in[NW-1]};
		ge = trial >= {1'b0, dmag};
		rem_out = ge ? 32'(trial - {1'b0, dmag}) : trial[31:0];
		nq_out = {nq_in[NW-2:0], ge};
	end
endmodule
`default_nettype wire

### src/q24_8_fixed_point_alu_top.sv
// q24_8_fixed_point_alu_top: pipelined signed fixed point alu
// same stages for every op; one beat per cycle unless the output waits
// division is one restoring step per stage, multiply uses one stage
// the whole pipe holds when the output beat waits; no item is lost
// reset clears the valid bits only
// depends on fxa_pkg, fxa_req_if, fxa_rsp_if, fxa_div_step
`default_nettype none
module q24_8_fixed_point_alu_top #(
	parameter int FRAC_W = fxa_pkg::FRAC_W_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fxa_req_if.sink  req,
	fxa_rsp_if.source rsp
);
	import fxa_pkg::*;

	localparam int NW = DW + FRAC_W;

	logic          en;
	logic          v_s [0:NW];
	ctl_t          ctl_s [0:NW];
	logic [NW-1:0] nq_s [0:NW];
	logic [31:0]   rem_s [0:NW];
	logic [63:0]   prod_s [0:NW];

	logic               out_v_q;
	logic signed [31:0] out_res_q;
	logic               out_cmp_q, out_dbz_q, out_sat_q;

	assign en = !out_v_q || rsp.ready;
	assign req.ready = en;

	// front stage
	logic signed [31:0] sa, sb;
	logic [31:0] ma, mb;
	ctl_t c0;
	always_comb begin
		sa = req.operand_a;
		sb = req.operand_b;
		ma = sa[31] ? 32'(-sa) : sa;
		mb = sb[31] ? 32'(-sb) : sb;
		c0.op = op_t'(req.req_type);
		c0.neg = sa[31] ^ sb[31];
		c0.dmag = mb;
		c0.res = '0;
		c0.cmp = 1'b0;
		c0.dbz = 1'b0;
		unique case (c0.op)
			OP_ADD: c0.res = sa + sb;
			OP_SUB: c0.res = sa - sb;
			OP_MUL: c0.res = '0;
			OP_DIV: c0.dbz = (sb == 0);
			OP_EQ: c0.cmp = (sa == sb);
			OP_NE: c0.cmp = (sa != sb);
			OP_LE: c0.cmp = (sa <= sb);
			OP_GE: c0.cmp = (sa >= sb);
			OP_LT: c0.cmp = (sa < sb);
			OP_GT: c0.cmp = (sa > sb);
			OP_MAX: c0.res = (sa > sb) ? sa : sb;
			OP_MIN: c0.res = (sa < sb) ? sa : sb;
			OP_INC: c0.res = sa + 32'sd1;
			OP_DEC: c0.res = sa - 32'sd1;
			OP_FROM_INT: c0.res = sa <<< FRAC_W;
			OP_TO_INT: c0.res = sa >>> FRAC_W;
			default: c0.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= c0;
			nq_s[0] <= {ma, {FRAC_W{1'b0}}};
			rem_s[0] <= '0;
			prod_s[0] <= '0;
		end
	end

	// division chain, product formed in the first step
	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [NW-1:0] nq_n;
		logic [31:0]   rem_n;
		fxa_div_step #(.NW(NW)) u_step (
			.nq_in(nq_s[k]), .rem_in(rem_s[k]), .dmag(ctl_s[k].dmag),
			.nq_out(nq_n), .rem_out(rem_n)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k+1] <= ctl_s[k];
				nq_s[k+1] <= nq_n;
				rem_s[k+1] <= rem_n;
				if (k == 0)
					prod_s[k+1] <= 64'(nq_s[k][NW-1 -: 32]) * 64'(ctl_s[k].dmag);
				else
					prod_s[k+1] <= prod_s[k];
			end
		end
	end

	// rounding and clamp
	ctl_t        cf;
	logic [63:0] mq, mm, m;
	logic [31:0] fres;
	logic        fsat;
	always_comb begin
		cf = ctl_s[NW];
		mq = 64'(nq_s[NW]) + 64'({rem_s[NW], 1'b0} >= {1'b0, cf.dmag});
		mm = (prod_s[NW] + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		m = (cf.op == OP_MUL) ? mm : mq;
		fsat = 1'b0;
		if (cf.neg) begin
			if (m > 64'h8000_0000) begin
				fsat = 1'b1;
				fres = 32'h8000_0000;
			end else begin
				fres = 32'(~m[31:0] + 32'd1);
			end
		end else begin
			if (m > 64'h7FFF_FFFF) begin
				fsat = 1'b1;
				fres = 32'h7FFF_FFFF;
			end else begin
				fres = m[31:0];
			end
		end
		if (!((cf.op == OP_MUL) || (cf.op == OP_DIV && !cf.dbz))) begin
			fres = cf.res;
			fsat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= fres;
			out_cmp_q <= cf.cmp;
			out_dbz_q <= cf.dbz;
			out_sat_q <= fsat;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.result_value = out_res_q;
	assign rsp.compare_true = out_cmp_q;
	assign rsp.divide_by_zero = out_dbz_q;
	assign rsp.saturated = out_sat_q;

`ifndef NO_ASSERTIONS
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("ready does not follow output stall");
	a_dbz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_by_zero |-> rsp.result_value == 0 && !rsp.saturated)
		else $error("divide by zero beat not clean");
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.compare_true |-> rsp.result_value == 0 && !rsp.saturated)
		else $error("compare beat carries a value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready |=> out_v_q && $stable(out_res_q))
		else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

### dv/q24_8_fixed_point_alu_checker.sv
// checker for the q24.8 fixed point alu: watches request and result beats,
// predicts each result and compares it field by field
// depends on fxa_pkg, fxa_req_if, fxa_rsp_if
`default_nettype none
module q24_8_fixed_point_alu_checker #(
	parameter int FRAC_W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	fxa_req_if.sink  req,
	fxa_rsp_if.sink  rsp,
	output int       fail_count,
	output int       pending,
	output int       req_beats,
	output int       rsp_beats
);
	timeunit 1ns;
	timeprecision 1ps;
	import fxa_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic        dbz;
		logic        sat;
	} alu_res_t;

	alu_res_t expected_q[$];

	function automatic logic [31:0] clamp32(logic [63:0] m, logic neg, ref logic sat);
		if (neg) begin
			if (m > 64'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-m);
		end
		if (m > 64'h7fff_ffff) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		return m[31:0];
	endfunction

	function automatic alu_res_t alu_predict(op_t op, logic signed [31:0] a,
		logic signed [31:0] b);
		alu_res_t r;
		logic [63:0] ma, mb, p, n, q, rm;
		logic sat;
		r = '0;
		sat = 1'b0;
		ma = a < 0 ? 64'(-64'(a)) : 64'(a);
		mb = b < 0 ? 64'(-64'(b)) : 64'(b);
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: begin
				p = (ma * mb + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
				r.value = clamp32(p, (a < 0) != (b < 0), sat);
			end
			OP_DIV: begin
				if (b == 0) begin
					r.dbz = 1'b1;
				end else begin
					n = ma << FRAC_W;
					q = n / mb;
					rm = n % mb;
					if (2 * rm >= mb) q++;
					r.value = clamp32(q, (a < 0) != (b < 0), sat);
				end
			end
			OP_EQ: r.cmp = a == b;
			OP_NE: r.cmp = a != b;
			OP_LE: r.cmp = a <= b;
			OP_GE: r.cmp = a >= b;
			OP_LT: r.cmp = a < b;
			OP_GT: r.cmp = a > b;
			OP_MAX: r.value = a > b ? a : b;
			OP_MIN: r.value = a < b ? a : b;
			OP_INC: r.value = a + 1;
			OP_DEC: r.value = a - 1;
			OP_FROM_INT: r.value = a << FRAC_W;
			default: r.value = a >>> FRAC_W;
		endcase
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		req_beats = 0;
		rsp_beats = 0;
	end

	always @(posedge clk) begin
		alu_res_t e;
		if (arst_n && req.valid && req.ready) begin
			expected_q.push_back(alu_predict(op_t'(req.req_type), req.operand_a,
				req.operand_b));
			req_beats++;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_beats++;
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				e = expected_q.pop_front();
				if (rsp.result_value !== e.value)
					report_mismatch($sformatf("result_value %h, want %h",
						rsp.result_value, e.value));
				if (rsp.compare_true !== e.cmp)
					report_mismatch($sformatf("compare_true %b, want %b",
						rsp.compare_true, e.cmp));
				if (rsp.divide_by_zero !== e.dbz)
					report_mismatch($sformatf("divide_by_zero %b, want %b",
						rsp.divide_by_zero, e.dbz));
				if (rsp.saturated !== e.sat)
					report_mismatch($sformatf("saturated %b, want %b",
						rsp.saturated, e.sat));
			end
		end
		pending = expected_q.size();
	end
endmodule
`default_nettype wire

### dv/q24_8_fixed_point_alu_top_tb.sv
// top of the q24.8 fixed point alu bench: clock, reset, request stimulus
// and result stalls across idle phases; verdict from the checker's count
// depends on fxa_pkg, fxa_req_if, fxa_rsp_if, the checker and the block
`default_nettype none
module q24_8_fixed_point_alu_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fxa_pkg::*;

	localparam int FRAC = 8;
	localparam int LATENCY = 32 + FRAC + 2;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending, req_beats, rsp_beats;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int dbz_seen = 0, sat_seen = 0;

	fxa_req_if req ();
	fxa_rsp_if rsp ();

	q24_8_fixed_point_alu_top #(.FRAC_W(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	q24_8_fixed_point_alu_checker #(.FRAC_W(FRAC)) chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending),
		.req_beats(req_beats), .rsp_beats(rsp_beats)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		if (rsp.valid && rsp.ready) begin
			dbz_seen += rsp.divide_by_zero;
			sat_seen += rsp.saturated;
		end
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'h8000_0000 + $urandom_range(2);
			1: return 32'h7fff_ffff - $urandom_range(2);
			2: return 32'($signed($urandom_range(1024)) - 512);
			3: return 32'($urandom_range(255)) << 8;
			4: return 32'($signed($urandom_range(65536)) - 32768);
			5: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(op_t op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		op_t op;
		logic [31:0] a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, ties, saturation, zero divisor
		send_beat(OP_ADD, 32'h7fff_ffff, 32'h1);
		send_beat(OP_SUB, 32'h8000_0000, 32'h1);
		send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(OP_MUL, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(OP_MUL, 32'h8000_0000, 32'h100);
		send_beat(OP_MUL, 32'h80, 32'h1);
		send_beat(OP_MUL, 32'hffff_ff80, 32'h1);
		send_beat(OP_DIV, 32'h100, 32'h0);
		send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
		send_beat(OP_DIV, 32'h8000_0000, 32'h8000_0000);
		send_beat(OP_DIV, 32'h1, 32'h200);
		send_beat(OP_DIV, 32'hffff_ffff, 32'h200);
		send_beat(OP_DIV, 32'h7fff_ffff, 32'h1);
		send_beat(OP_EQ, 32'h5, 32'h5);
		send_beat(OP_NE, 32'h5, 32'h5);
		send_beat(OP_LE, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(OP_GE, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(OP_LT, 32'hffff_ffff, 32'h0);
		send_beat(OP_GT, 32'h0, 32'hffff_ffff);
		send_beat(OP_MAX, 32'h1234, 32'h1234);
		send_beat(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
		send_beat(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
		send_beat(OP_FROM_INT, 32'h0100_0000, 32'h0);
		send_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);

		// random in four idle phases, one drain to empty after each phase
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 45; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 45; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			for (int i = 0; i < 182; i++) begin
				op = op_t'($urandom_range(15));
				a = pick_operand();
				b = pick_operand();
				send_beat(op, a, b);
			end
			drain_results();
		end

		stall_pct = 0;
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d requests and %0d results over four idle phases",
			req_beats, rsp_beats);
		$display("%0d divide by zero and %0d saturated results seen", dbz_seen, sat_seen);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
